// File: hw/rtl/lc3c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lc3c_pkg;
  typedef enum logic [2:0] {
    EV_LOADED  = 3'd0,
    EV_STEPPED = 3'd1,
    EV_NEWLINE = 3'd2,
    EV_PRINT   = 3'd3,
    EV_HALTED  = 3'd4
  } event_t;

  typedef enum logic [3:0] {
    OP_BR = 4'd0, OP_ADD = 4'd1, OP_LD = 4'd2, OP_ST = 4'd3,
    OP_JSR = 4'd4, OP_AND = 4'd5, OP_LDR = 4'd6, OP_STR = 4'd7,
    OP_RTI = 4'd8, OP_NOT = 4'd9, OP_LDI = 4'd10, OP_STI = 4'd11,
    OP_JMP = 4'd12, OP_RES = 4'd13, OP_LEA = 4'd14, OP_TRAP = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_FETCH, ST_DECODE, ST_MEM1, ST_MEM2, ST_DONE
  } state_t;

  localparam logic [7:0] TRAP_HALT  = 8'h25;
  localparam logic [7:0] TRAP_NEWLN = 8'h26;
  localparam logic [7:0] TRAP_PRINT = 8'h27;

  typedef struct packed {
    logic clear_en;
    logic load_en;
    logic fetch_en;
    logic decode_en;
    logic mem1_en;
    logic mem2_en;
    logic out_en;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic halted;
    logic need_mem1;
    logic need_mem2;
  } stat_t;
endpackage
`default_nettype wire

// File: hw/rtl/lc3_instruction_core_top.sv
// Steps: a load writes one memory word and reports; an instruction runs fetch,
// decode/execute, up to two memory accesses and result; an execute
// transaction while halted goes straight to its result without a fetch.
// Throughput: one transaction at a time.
// Reset: synchronous rst clears registers, then a clearing pass zeroes
// all 2**ADDR_BITS memory words before the first transaction.
`timescale 1ns / 1ps
`default_nettype none
module lc3_instruction_core_top
  import lc3c_pkg::*;
#(
  parameter int ADDR_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // load_address, load_word
  input  wire logic        s_tuser,  // opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata   // event_res, print_value, next_pc, zero pad
);
  cmd_t cmd;
  stat_t stat;
  logic [2:0] ev;
  logic [15:0] pv, pc;
  logic op_q;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) op_q <= s_tuser;
  end

  lc3c_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_op(s_tuser),
    .in_ready(s_tready), .out_free(!m_tvalid || m_tready),
    .stat(stat), .cmd(cmd)
  );

  lc3c_dp #(.ADDR_BITS(ADDR_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_op(op_q),
    .in_addr(s_tdata[15:0]), .in_word(s_tdata[31:16]),
    .stat(stat), .ev(ev), .pv(pv), .pc_out(pc)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.out_en) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
    if (cmd.out_en) m_tdata <= {5'd0, pc, pv, ev};
  end
endmodule
`default_nettype wire

// File: hw/rtl/lc3c_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lc3c_ctrl
  import lc3c_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_op,
  output logic       in_ready,
  input  wire logic  out_free,
  input  wire stat_t stat,
  output cmd_t       cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          if (!in_op) begin
            cmd.load_en = 1'b1;
            state_next = ST_DONE;
          end else if (stat.halted) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch_en = 1'b1;
        state_next = ST_DECODE;
      end
      ST_DECODE: begin
        cmd.decode_en = 1'b1;
        state_next = stat.need_mem1 ? ST_MEM1 : ST_DONE;
      end
      ST_MEM1: begin
        cmd.mem1_en = 1'b1;
        state_next = stat.need_mem2 ? ST_MEM2 : ST_DONE;
      end
      ST_MEM2: begin
        cmd.mem2_en = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.out_en = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/lc3c_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module lc3c_dp
  import lc3c_pkg::*;
#(
  parameter int ADDR_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  input  wire logic        in_op,
  input  wire logic [15:0] in_addr,
  input  wire logic [15:0] in_word,
  output stat_t            stat,
  output logic [2:0]       ev,
  output logic [15:0]      pv,
  output logic [15:0]      pc_out
);
  logic [15:0] mem [2**ADDR_BITS];
  logic [ADDR_BITS-1:0] clr_addr;
  logic [15:0] rf [8];
  logic [15:0] pc, pc_n, ir, rdata, eff, wdat;
  logic [2:0] cc;
  logic halted;
  logic [2:0] evr;
  logic [15:0] pvr;
  logic [ADDR_BITS-1:0] raddr, waddr;
  logic we;
  logic is_ld, is_st;
  logic [3:0] op;
  logic [2:0] d, s1, s2;
  logic [15:0] off9, off11, off6, imm5, opnd, alu, pc1;

  assign op = ir[15:12];
  assign d = ir[11:9];
  assign s1 = ir[8:6];
  assign s2 = ir[2:0];
  assign off9 = {{7{ir[8]}}, ir[8:0]};
  assign off11 = {{5{ir[10]}}, ir[10:0]};
  assign off6 = {{10{ir[5]}}, ir[5:0]};
  assign imm5 = {{11{ir[4]}}, ir[4:0]};
  assign opnd = ir[5] ? imm5 : rf[s2];
  assign pc1 = pc + 16'd1;

  always_comb begin
    eff = pc1 + off9;
    if (op == OP_LDR || op == OP_STR) eff = rf[s1] + off6;
  end

  assign stat.clear_done = (clr_addr == {ADDR_BITS{1'b1}});
  assign stat.halted = halted;
  assign stat.need_mem1 = is_ld || is_st || op == OP_LDI || op == OP_STI;
  assign stat.need_mem2 = op == OP_LDI || op == OP_STI;
  assign is_ld = op == OP_LD || op == OP_LDR;
  assign is_st = op == OP_ST || op == OP_STR;

  always_comb begin
    we = 1'b0;
    waddr = in_addr[ADDR_BITS-1:0];
    wdat = in_word;
    raddr = pc[ADDR_BITS-1:0];
    if (cmd.clear_en) begin
      we = 1'b1;
      waddr = clr_addr;
      wdat = '0;
    end else if (cmd.load_en) begin
      we = 1'b1;
    end else if (cmd.decode_en) begin
      raddr = eff[ADDR_BITS-1:0];
      if (is_st) begin
        we = 1'b1;
        waddr = eff[ADDR_BITS-1:0];
        wdat = rf[d];
      end
    end else if (cmd.mem1_en) begin
      raddr = rdata[ADDR_BITS-1:0];
      if (op == OP_STI) begin
        we = 1'b1;
        waddr = rdata[ADDR_BITS-1:0];
        wdat = rf[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdat;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear_en) clr_addr <= clr_addr + 1'b1;
  end

  function automatic logic [2:0] flags(input logic [15:0] v);
    flags = v[15] ? 3'b100 : (v == 16'd0 ? 3'b010 : 3'b001);
  endfunction

  always_comb begin
    alu = rf[s1] + opnd;
    unique case (op)
      OP_AND: alu = rf[s1] & opnd;
      OP_NOT: alu = ~rf[s1];
      OP_LEA: alu = pc1 + off9;
      default: ;
    endcase
  end

  always_comb begin
    pc_n = pc1;
    if (op == OP_BR && (d & cc) != 3'd0) pc_n = pc1 + off9;
    else if (op == OP_JSR) pc_n = ir[11] ? pc1 + off11 : rf[s1];
    else if (op == OP_JMP) pc_n = rf[s1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
      cc <= '0;
      halted <= 1'b0;
      for (int i = 0; i < 8; i++) rf[i] <= '0;
    end else begin
      if (cmd.decode_en) begin
        pc <= pc_n;
        if (op == OP_ADD || op == OP_AND || op == OP_NOT || op == OP_LEA) begin
          rf[d] <= alu;
          cc <= flags(alu);
        end
        if (op == OP_JSR) rf[7] <= pc1;
        if (op == OP_TRAP && ir[7:0] == TRAP_HALT) halted <= 1'b1;
      end
      if ((cmd.mem1_en && is_ld) || (cmd.mem2_en && op == OP_LDI)) begin
        rf[d] <= rdata;
        cc <= flags(rdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch_en) begin
      ir <= rdata;
      evr <= EV_STEPPED;
      pvr <= '0;
    end else if (cmd.load_en) begin
      evr <= EV_LOADED;
      pvr <= '0;
    end else if (cmd.decode_en && op == OP_TRAP) begin
      if (ir[7:0] == TRAP_HALT) evr <= EV_HALTED;
      else if (ir[7:0] == TRAP_NEWLN) evr <= EV_NEWLINE;
      else if (ir[7:0] == TRAP_PRINT) begin
        evr <= EV_PRINT;
        pvr <= rf[0];
      end
    end
  end

  always_comb begin
    ev = evr;
    pv = pvr;
    if (in_op && halted && evr != EV_HALTED) begin
      ev = EV_HALTED;
      pv = '0;
    end
  end
  assign pc_out = pc;
endmodule
`default_nettype wire

// File: dv/lc3_instruction_core_top_tb.sv
`timescale 1ns / 1ps
module lc3_instruction_core_top_tb;
  import lc3c_pkg::*;

  localparam int ADDR_BITS = 16;
  localparam int MEM_WORDS = 1 << ADDR_BITS;
  localparam int WATCHDOG_LIMIT = 4 * MEM_WORDS + 20000;

  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] pv;
    event_t      ev;
  } core_result_t;

  class core_scoreboard;
    core_result_t pending[$];
    int errors;

    function void note_result(core_result_t r);
      pending.push_back(r);
    endfunction

    task check_result(core_result_t got);
      core_result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result ev=%0d pc=%h", got.ev, got.pc));
      end else begin
        want = pending.pop_front();
        if (got.ev !== want.ev)
          report_mismatch($sformatf("event got %0d want %0d", got.ev, want.ev));
        if (got.pv !== want.pv)
          report_mismatch($sformatf("print_value got %h want %h", got.pv, want.pv));
        if (got.pc !== want.pc)
          report_mismatch($sformatf("next_pc got %h want %h", got.pc, want.pc));
      end
    endtask

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;

  lc3_instruction_core_top #(.ADDR_BITS(ADDR_BITS)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  logic [15:0] mem_model[MEM_WORDS];
  logic [15:0] regs_model[8];
  logic [15:0] pc_model;
  logic [2:0]  flags_model;
  logic        halted_model;
  core_scoreboard board;
  bit          quiet_tail;
  int          idle_cycles;
  bit          timed_out;
  int          ready_stall = 0;

  function automatic logic [15:0] sign_ext(logic [15:0] v, int bits);
    logic [15:0] m;
    m = (16'h1 << bits) - 16'h1;
    v = v & m;
    return v[bits-1] ? (v | ~m) : v;
  endfunction

  function automatic logic [15:0] mask_addr(logic [15:0] a);
    return a & 16'(MEM_WORDS - 1);
  endfunction

  task automatic write_reg_flags(int d, logic [15:0] v);
    regs_model[d] = v;
    flags_model = v[15] ? 3'b100 : (v == 0 ? 3'b010 : 3'b001);
  endtask

  task automatic predict_core(logic is_exec, logic [15:0] addr, logic [15:0] word,
                              output core_result_t r);
    logic [15:0] ir, pc, t;
    int d, s1, s2;
    r.ev = EV_STEPPED;
    r.pv = 0;
    if (!is_exec) begin
      mem_model[mask_addr(addr)] = word;
      r.ev = EV_LOADED;
    end else if (halted_model) begin
      r.ev = EV_HALTED;
    end else begin
      ir = mem_model[mask_addr(pc_model)];
      pc = pc_model + 16'd1;
      d = ir[11:9];
      s1 = ir[8:6];
      s2 = ir[2:0];
      t = ir[5] ? sign_ext(ir, 5) : regs_model[s2];
      case (op_t'(ir[15:12]))
        OP_BR:  if ((ir[11:9] & flags_model) != 0) pc = pc + sign_ext(ir, 9);
        OP_ADD: write_reg_flags(d, regs_model[s1] + t);
        OP_LD:  write_reg_flags(d, mem_model[mask_addr(pc + sign_ext(ir, 9))]);
        OP_ST:  mem_model[mask_addr(pc + sign_ext(ir, 9))] = regs_model[d];
        OP_JSR: begin
          t = pc;
          pc = ir[11] ? pc + sign_ext(ir, 11) : regs_model[s1];
          regs_model[7] = t;
        end
        OP_AND: write_reg_flags(d, regs_model[s1] & t);
        OP_LDR: write_reg_flags(d, mem_model[mask_addr(regs_model[s1] + sign_ext(ir, 6))]);
        OP_STR: mem_model[mask_addr(regs_model[s1] + sign_ext(ir, 6))] = regs_model[d];
        OP_NOT: write_reg_flags(d, ~regs_model[s1]);
        OP_LDI: write_reg_flags(d,
                  mem_model[mask_addr(mem_model[mask_addr(pc + sign_ext(ir, 9))])]);
        OP_STI: mem_model[mask_addr(mem_model[mask_addr(pc + sign_ext(ir, 9))])] =
                  regs_model[d];
        OP_JMP: pc = regs_model[s1];
        OP_LEA: write_reg_flags(d, pc + sign_ext(ir, 9));
        OP_TRAP: begin
          if (ir[7:0] == TRAP_HALT) begin
            halted_model = 1;
            r.ev = EV_HALTED;
          end else if (ir[7:0] == TRAP_NEWLN) begin
            r.ev = EV_NEWLINE;
          end else if (ir[7:0] == TRAP_PRINT) begin
            r.ev = EV_PRINT;
            r.pv = regs_model[0];
          end
        end
        default: ;
      endcase
      pc_model = pc;
    end
    r.pc = pc_model;
  endtask

  task automatic send_item(logic is_exec, logic [15:0] addr, logic [15:0] word);
    core_result_t r;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= is_exec;
    s_tdata <= {word, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_core(is_exec, addr, word, r);
    board.note_result(r);
  endtask

  task automatic load_word(logic [15:0] addr, logic [15:0] word);
    send_item(0, addr, word);
  endtask

  task automatic exec_one();
    send_item(1, 16'($urandom), 16'($urandom));
  endtask

  task automatic drain_results();
    s_tvalid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0 && !timed_out) @(posedge clk);
  endtask

  function automatic logic [15:0] random_instr();
    logic [15:0] ir;
    ir = 16'($urandom);
    case ($urandom_range(0, 9))
      0: ir[15:12] = OP_TRAP;
      1: ir = {OP_TRAP, 4'h0, 8'(TRAP_PRINT)};
      2: ir = {OP_TRAP, 4'h0, 8'(TRAP_NEWLN)};
      3: ir[15:12] = OP_BR;
      default: if (ir[15:12] == OP_TRAP && ir[7:0] == TRAP_HALT) ir[0] = 0;
    endcase
    return ir;
  endfunction

  always @(posedge clk) begin
    if (rst || quiet_tail) begin
      m_tready <= 1;
      ready_stall <= 0;
    end else if (ready_stall > 0) begin
      m_tready <= 0;
      ready_stall <= ready_stall - 1;
    end else if (m_tready && $urandom_range(0, 4) == 0) begin
      m_tready <= 0;
      ready_stall <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_result(core_result_t'(m_tdata[34:0]));
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [15:0] base;
    board = new();
    foreach (mem_model[i]) mem_model[i] = 0;
    foreach (regs_model[i]) regs_model[i] = 0;
    pc_model = 0;
    flags_model = 0;
    halted_model = 0;
    quiet_tail = 0;
    timed_out = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // directed: zero memory executes as BR with no flags
    exec_one();
    load_word(16'hffff, 16'hffff);
    load_word(16'h0001, {OP_ADD, 3'd0, 3'd0, 1'b1, 5'b01111});
    load_word(16'h0002, {OP_ADD, 3'd1, 3'd0, 1'b1, 5'b10000});
    load_word(16'h0003, {OP_TRAP, 4'h0, 8'(TRAP_PRINT)});
    load_word(16'h0004, {OP_NOT, 3'd2, 3'd0, 6'h3f});
    load_word(16'h0005, {OP_TRAP, 4'h0, 8'(TRAP_NEWLN)});
    load_word(16'h0006, {OP_BR, 3'b111, 9'h1ff});
    load_word(16'h0006, {OP_LEA, 3'd3, 9'h100});
    load_word(16'h0007, {OP_STI, 3'd2, 9'h0f7});
    load_word(16'h00ff, 16'h8000);
    load_word(16'h0008, {OP_LDI, 3'd4, 9'h0f6});
    load_word(16'h0009, {OP_JSR, 1'b1, 11'h7f6});
    repeat (9) exec_one();
    load_word(16'h0000, {OP_JMP, 3'd0, 3'd3, 6'h00});
    exec_one();
    exec_one();
    drain_results();

    // random programs; reset is one-shot, so the loop stops once the core halts
    for (int seg = 0; seg < 30 && !halted_model; seg++) begin
      base = pc_model;
      for (int k = 0; k < 12; k++) load_word(base + 16'(k), random_instr());
      repeat (4) load_word(16'($urandom), 16'($urandom));
      repeat (8) exec_one();
      if (seg == 12) drain_results();
    end
    for (int k = 0; k < 8 && !halted_model; k++) begin
      load_word(pc_model, {OP_TRAP, 4'h0, 8'(TRAP_HALT)});
      exec_one();
    end
    quiet_tail = 1;
    repeat (20) begin
      load_word(16'($urandom), 16'($urandom));
      exec_one();
    end
    drain_results();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/lc3c_pkg.sv
hw/rtl/lc3c_ctrl.sv
hw/rtl/lc3c_dp.sv
hw/rtl/lc3_instruction_core_top.sv
dv/lc3_instruction_core_top_tb.sv
